@@ hw/rtl/scw_pkg.sv @@
// Shared types and constants for the shortest covering window block.
package scw_pkg;

    // Fixed field widths of the token and result channels
    localparam int TOKEN_W = 9;
    localparam int DIST_W  = 9;
    localparam int LEN_W   = 11;

    // Result handed from the control unit to the output register
    typedef struct packed {
        logic [DIST_W-1:0] distinct_keywords;
        logic [LEN_W-1:0]  shortest_length;
    } t_result;

endpackage

@@ hw/rtl/scw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module scw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/scw_ctrl.sv @@
// Sequencer for token loading, the two-pointer window pass, the result hand-off and the seen/count clearing sweep.
module scw_ctrl #(
    parameter int MAX_TOKENS   = 1024,
    parameter int MAX_KEYWORDS = 256,
    localparam int TA = $clog2(MAX_TOKENS),
    localparam int TW = $clog2(MAX_TOKENS + 1),
    localparam int KA = $clog2(MAX_KEYWORDS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // token channel
    input  logic                        i_valid,
    input  logic [scw_pkg::TOKEN_W-1:0] i_token_index,
    input  logic                        i_last_token,
    output logic                        o_stall,
    // token store
    output logic                        o_tok_we,
    output logic [TA-1:0]               o_tok_waddr,
    output logic [scw_pkg::TOKEN_W-1:0] o_tok_wdata,
    output logic [TA-1:0]               o_tok_raddr,
    input  logic [scw_pkg::TOKEN_W-1:0] i_tok_rdata,
    // keyword seen flags, used while loading
    output logic                        o_seen_we,
    output logic [KA-1:0]               o_seen_waddr,
    output logic                        o_seen_wdata,
    output logic [KA-1:0]               o_seen_raddr,
    input  logic                        i_seen_rdata,
    // window occurrence counts
    output logic                        o_cnt_we,
    output logic [KA-1:0]               o_cnt_waddr,
    output logic [TW-1:0]               o_cnt_wdata,
    output logic [KA-1:0]               o_cnt_raddr,
    input  logic [TW-1:0]               i_cnt_rdata,
    // result toward the output register
    output logic                        o_res_valid,
    output scw_pkg::t_result            o_res,
    input  logic                        i_out_free
);

    localparam int DW = $clog2(MAX_KEYWORDS + 1);

    typedef enum logic [10:0] {
        S_LOAD  = 11'b000_0000_0001,
        S_LCHK  = 11'b000_0000_0010,
        S_START = 11'b000_0000_0100,
        S_RREAD = 11'b000_0000_1000,
        S_RDATA = 11'b000_0001_0000,
        S_RINC  = 11'b000_0010_0000,
        S_CHECK = 11'b000_0100_0000,
        S_LDATA = 11'b000_1000_0000,
        S_LDEC  = 11'b001_0000_0000,
        S_DONE  = 11'b010_0000_0000,
        S_CLEAR = 11'b100_0000_0000
    } t_state;

    t_state        r_state,   n_state;
    logic [TW-1:0] r_n,       n_n;
    logic [DW-1:0] r_distinct, n_distinct;
    logic [DW-1:0] r_covered, n_covered;
    logic [TW-1:0] r_r,       n_r;
    logic [TW-1:0] r_l,       n_l;
    logic [TW-1:0] r_best,    n_best;
    logic [KA-1:0] r_key,     n_key;
    logic          r_last,    n_last;
    logic [KA-1:0] r_sweep,   n_sweep;

    logic [31:0]   w_in_tok32;
    logic          w_in_hit;
    logic [KA-1:0] w_in_key;
    logic [31:0]   w_rd_tok32;
    logic          w_rd_hit;
    logic [KA-1:0] w_rd_key;
    logic          w_in_acc;
    logic          w_full;
    logic [TW-1:0] w_len;
    logic [31:0]   w_dist32;
    logic [31:0]   w_best32;

    // Classify the incoming token and the token read back from the store
    assign w_in_tok32 = 32'(i_token_index);
    assign w_in_hit   = (w_in_tok32 != 32'd0) && (w_in_tok32 <= 32'(MAX_KEYWORDS));
    assign w_in_key   = w_in_tok32[KA-1:0];
    assign w_rd_tok32 = 32'(i_tok_rdata);
    assign w_rd_hit   = (w_rd_tok32 != 32'd0) && (w_rd_tok32 <= 32'(MAX_KEYWORDS));
    assign w_rd_key   = w_rd_tok32[KA-1:0];

    assign o_stall  = (r_state != S_LOAD);
    assign w_in_acc = i_valid && !o_stall;
    assign w_full   = (r_n == TW'(MAX_TOKENS));
    assign w_len    = r_r - r_l + 1'b1;

    // Memory ports
    assign o_tok_waddr  = r_n[TA-1:0];
    assign o_tok_wdata  = i_token_index;
    assign o_tok_raddr  = (r_state == S_CHECK) ? r_l[TA-1:0] : r_r[TA-1:0];
    assign o_seen_raddr = w_in_key;
    assign o_seen_waddr = (r_state == S_CLEAR) ? r_sweep : r_key;
    assign o_seen_wdata = (r_state == S_LCHK);
    assign o_cnt_raddr  = w_rd_key;
    assign o_cnt_waddr  = (r_state == S_CLEAR) ? r_sweep : r_key;

    always_comb begin
        priority if (r_state == S_RINC) begin
            o_cnt_wdata = i_cnt_rdata + 1'b1;
        end else if (r_state == S_LDEC) begin
            o_cnt_wdata = i_cnt_rdata - 1'b1;
        end else begin
            o_cnt_wdata = '0;
        end
    end

    // Result
    assign w_dist32               = 32'(r_distinct);
    assign w_best32               = 32'(r_best);
    assign o_res_valid            = (r_state == S_DONE);
    assign o_res.distinct_keywords = w_dist32[scw_pkg::DIST_W-1:0];
    assign o_res.shortest_length   = w_best32[scw_pkg::LEN_W-1:0];

    // Next state and counters
    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_distinct = r_distinct;
        n_covered  = r_covered;
        n_r        = r_r;
        n_l        = r_l;
        n_best     = r_best;
        n_key      = r_key;
        n_last     = r_last;
        n_sweep    = r_sweep;
        o_tok_we   = 1'b0;
        o_seen_we  = 1'b0;
        o_cnt_we   = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    // store the token unless the store is full
                    if (!w_full) begin
                        o_tok_we = 1'b1;
                        n_n      = r_n + 1'b1;
                    end
                    n_key  = w_in_key;
                    n_last = i_last_token;
                    if (!w_full && w_in_hit) begin
                        n_state = S_LCHK;
                    end else if (i_last_token) begin
                        n_state = S_START;
                    end
                end
            end
            S_LCHK: begin
                // first sight of this keyword in the run
                if (!i_seen_rdata) begin
                    o_seen_we  = 1'b1;
                    n_distinct = r_distinct + 1'b1;
                end
                n_state = r_last ? S_START : S_LOAD;
            end
            S_START: begin
                n_r       = '0;
                n_l       = '0;
                n_covered = '0;
                if (r_distinct == '0) begin
                    n_best  = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RREAD;
                end
            end
            S_RREAD: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_key   = w_rd_key;
                n_state = w_rd_hit ? S_RINC : S_CHECK;
            end
            S_RINC: begin
                // grow the window on the right
                o_cnt_we = 1'b1;
                if (i_cnt_rdata == '0) begin
                    n_covered = r_covered + 1'b1;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_covered == r_distinct) begin
                    if (w_len < r_best) begin
                        n_best = w_len;
                    end
                    n_state = S_LDATA;
                end else if (r_r + 1'b1 == r_n) begin
                    n_state = S_DONE;
                end else begin
                    n_r     = r_r + 1'b1;
                    n_state = S_RREAD;
                end
            end
            S_LDATA: begin
                n_key = w_rd_key;
                if (w_rd_hit) begin
                    n_state = S_LDEC;
                end else begin
                    n_l     = r_l + 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_LDEC: begin
                // shrink the window on the left
                o_cnt_we = 1'b1;
                if (i_cnt_rdata == TW'(1)) begin
                    n_covered = r_covered - 1'b1;
                end
                n_l     = r_l + 1'b1;
                n_state = S_CHECK;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_sweep    = '0;
                    n_n        = '0;
                    n_distinct = '0;
                    n_state    = S_CLEAR;
                end
            end
            S_CLEAR: begin
                // zero one keyword entry per cycle
                o_seen_we = 1'b1;
                o_cnt_we  = 1'b1;
                if (r_sweep == KA'(MAX_KEYWORDS)) begin
                    n_best  = '1;
                    n_state = S_LOAD;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_n        <= '0;
            r_distinct <= '0;
            r_covered  <= '0;
            r_r        <= '0;
            r_l        <= '0;
            r_best     <= '1;
            r_last     <= 1'b0;
            r_sweep    <= '0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_distinct <= n_distinct;
            r_covered  <= n_covered;
            r_r        <= n_r;
            r_l        <= n_l;
            r_best     <= n_best;
            r_last     <= n_last;
            r_sweep    <= n_sweep;
        end
    end

    // Key of the entry under read-modify-write
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

@@ hw/rtl/shortest_covering_window.sv @@
// Top level of the shortest covering window block: memories, sequencer and output register.
//
// Input channel (i_valid / o_stall): one token per transfer, already mapped to a
// keyword number (1..MAX_KEYWORDS) or 0. i_last_token closes the run. Tokens past
// MAX_TOKENS are dropped, but a last token still closes the run.
// Output channel (o_valid / i_stall): one result per run, the number of distinct
// keywords and the length of the shortest span holding all of them (0 if none).
// Loading takes a non-keyword token in S_LOAD; a keyword token also passes through
// S_LCHK, with o_stall high, for the read-modify-write of the seen-flag memory.
// After the last token the window pass walks the token store with two pointers:
// a right step goes through S_RREAD, S_RDATA, S_RINC (keywords only) and S_CHECK,
// a left step through S_LDATA, S_LDEC (keywords only) and S_CHECK, as the token
// and count memories have registered reads. The result sits in an output register;
// a stalled result holds there while all MAX_KEYWORDS+1 entries of the seen-flag
// and count memories are cleared, after which the next run's tokens are taken.
// A second result waits until the first has been transferred. Reset (synchronous,
// active low) starts the same clearing sweep, with o_stall high until it ends.
module shortest_covering_window #(
    parameter int MAX_TOKENS   = 1024,
    parameter int MAX_KEYWORDS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [scw_pkg::TOKEN_W-1:0] i_token_index,
    input  logic                        i_last_token,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [scw_pkg::DIST_W-1:0]  o_distinct_keywords,
    output logic [scw_pkg::LEN_W-1:0]   o_shortest_length
);

    localparam int TA = $clog2(MAX_TOKENS);
    localparam int TW = $clog2(MAX_TOKENS + 1);
    localparam int KA = $clog2(MAX_KEYWORDS + 1);

    logic                        w_tok_we;
    logic [TA-1:0]               w_tok_waddr;
    logic [scw_pkg::TOKEN_W-1:0] w_tok_wdata;
    logic [TA-1:0]               w_tok_raddr;
    logic [scw_pkg::TOKEN_W-1:0] w_tok_rdata;
    logic                        w_seen_we;
    logic [KA-1:0]               w_seen_waddr;
    logic                        w_seen_wdata;
    logic [KA-1:0]               w_seen_raddr;
    logic                        w_seen_rdata;
    logic                        w_cnt_we;
    logic [KA-1:0]               w_cnt_waddr;
    logic [TW-1:0]               w_cnt_wdata;
    logic [KA-1:0]               w_cnt_raddr;
    logic [TW-1:0]               w_cnt_rdata;
    logic                        w_res_valid;
    scw_pkg::t_result            w_res;
    logic                        w_out_free;

    logic                        r_out_valid;
    scw_pkg::t_result            r_out;

    scw_ctrl #(
        .MAX_TOKENS   (MAX_TOKENS),
        .MAX_KEYWORDS (MAX_KEYWORDS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_token_index (i_token_index),
        .i_last_token  (i_last_token),
        .o_stall       (o_stall),
        .o_tok_we      (w_tok_we),
        .o_tok_waddr   (w_tok_waddr),
        .o_tok_wdata   (w_tok_wdata),
        .o_tok_raddr   (w_tok_raddr),
        .i_tok_rdata   (w_tok_rdata),
        .o_seen_we     (w_seen_we),
        .o_seen_waddr  (w_seen_waddr),
        .o_seen_wdata  (w_seen_wdata),
        .o_seen_raddr  (w_seen_raddr),
        .i_seen_rdata  (w_seen_rdata),
        .o_cnt_we      (w_cnt_we),
        .o_cnt_waddr   (w_cnt_waddr),
        .o_cnt_wdata   (w_cnt_wdata),
        .o_cnt_raddr   (w_cnt_raddr),
        .i_cnt_rdata   (w_cnt_rdata),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .i_out_free    (w_out_free)
    );

    // Token store
    scw_ram #(
        .WIDTH (scw_pkg::TOKEN_W),
        .DEPTH (MAX_TOKENS)
    ) u_tok_ram (
        .i_clk   (i_clk),
        .i_we    (w_tok_we),
        .i_waddr (w_tok_waddr),
        .i_wdata (w_tok_wdata),
        .i_raddr (w_tok_raddr),
        .o_rdata (w_tok_rdata)
    );

    // Keyword seen flags
    scw_ram #(
        .WIDTH (1),
        .DEPTH (MAX_KEYWORDS + 1)
    ) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (w_seen_we),
        .i_waddr (w_seen_waddr),
        .i_wdata (w_seen_wdata),
        .i_raddr (w_seen_raddr),
        .o_rdata (w_seen_rdata)
    );

    // Window occurrence counts
    scw_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_KEYWORDS + 1)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rdata)
    );

    // Output register: load a new result when empty or being transferred
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_distinct_keywords = r_out.distinct_keywords;
    assign o_shortest_length   = r_out.shortest_length;

endmodule

@@ hw/rtl/scw_chk.sv @@
// Port-level checker for the shortest covering window block, bound to the top level.
module scw_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic                        i_last_token,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [scw_pkg::DIST_W-1:0]  o_distinct_keywords,
    input  logic [scw_pkg::LEN_W-1:0]   o_shortest_length
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_distinct_keywords)
            && $stable(o_shortest_length))
        else $error("stalled result changed or dropped");

    // Zero length exactly when no keyword was seen
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_distinct_keywords == '0) == (o_shortest_length == '0)))
        else $error("length and distinct count disagree on an empty run");

    // A span holding d distinct keywords is at least d tokens long
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_shortest_length) >= 32'(o_distinct_keywords)))
        else $error("shortest length below distinct keyword count");

    // Stop taking tokens right after the last one of a run
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_token |=> o_stall)
        else $error("token taken right after the last token");

endmodule

bind shortest_covering_window scw_chk u_scw_chk (.*);
